// File: design/tcce_pkg.sv
// shared types and constants for the text console cursor engine
package tcce_pkg;

    // fixed field widths
    localparam int CELL_W   = 14;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CMD_W    = 2;
    localparam int CIDX_W   = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    // special characters
    localparam logic [CHAR_W-1:0] CHR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHR_BLANK     = 8'd32;

    // attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 2'd0,
        CMD_UP     = 2'd1,
        CMD_DOWN   = 2'd2,
        CMD_SELECT = 2'd3
    } cmd_t;

endpackage

// File: design/text_console_cursor_engine_unit.sv
// text console cursor engine: command stream in, cell write and cursor report out
//
//  channel   | ports                    | contents
//  ----------+--------------------------+-----------------------------------------
//  command   | s_tvalid/s_tready/s_tdata/s_tuser | one command per transaction
//  result    | m_tvalid/m_tready/m_tdata/m_tuser | one result per command
//  attribute | cfg_we/cfg_wdata         | attribute byte, written while cfg_we is high
//
//  one command per cycle while results are taken; each passes through the
//  input register, then the result register; the cursor and view update lies
//  between them and is written back in the same edge as the result
//  per-console cursor and view state resets to each slice origin at once
//  a stalled result holds the input register; the next command still enters
//  while the result register drains
module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int NUM_CONSOLES  = 4,
    parameter int SCREEN_COLS   = 80,
    parameter int SCREEN_ROWS   = 25,
    parameter int CONSOLE_CELLS = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] console_index, [10:3] char_code, [15:11] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [13:0] mem_cell, [21:14] mem_char, [29:22] mem_attr,
    // [43:30] cursor_pos, [57:44] view_start, [63:58] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] mem_write, [1] flush
    output logic [M_TUSER_W-1:0] m_tuser,
    // attribute register
    input  logic                 cfg_we,
    input  logic [ATTR_W-1:0]    cfg_wdata
);

    // derived geometry
    localparam int VIEW_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int MAX_ROW    = (VIEW_CELLS >= CONSOLE_CELLS) ? 0 :
                                (CONSOLE_CELLS - VIEW_CELLS + SCREEN_COLS - 1) / SCREEN_COLS;
    localparam int MAX_WO     = MAX_ROW * SCREEN_COLS;
    localparam int IDX_W      = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
    localparam int OFF_W      = $clog2(CONSOLE_CELLS);
    localparam int ROW_W      = $clog2(CONSOLE_CELLS / SCREEN_COLS + 1);
    localparam int COL_W      = $clog2(SCREEN_COLS);
    localparam int SUM_W      = $clog2(CONSOLE_CELLS + VIEW_CELLS + SCREEN_COLS + 1);

    localparam logic [SUM_W-1:0] COLS_S   = SUM_W'(SCREEN_COLS);
    localparam logic [SUM_W-1:0] ROWS_S   = SUM_W'(SCREEN_ROWS);
    localparam logic [SUM_W-1:0] CELLS_S  = SUM_W'(CONSOLE_CELLS);
    localparam logic [SUM_W-1:0] VIEW_S   = SUM_W'(VIEW_CELLS);
    localparam logic [SUM_W-1:0] MAXROW_S = SUM_W'(MAX_ROW);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);

    // input register
    logic                 in_valid_reg;
    cmd_t                 cmd_reg;
    logic [CIDX_W-1:0]    idx_reg;
    logic [CHAR_W-1:0]    char_reg;

    // per-console state, offsets relative to the slice origin
    logic [OFF_W-1:0]     cur_off_reg  [NUM_CONSOLES];
    logic [ROW_W-1:0]     cur_row_reg  [NUM_CONSOLES];
    logic [COL_W-1:0]     cur_col_reg  [NUM_CONSOLES];
    logic [OFF_W-1:0]     win_off_reg  [NUM_CONSOLES];
    logic [ROW_W-1:0]     win_row_reg  [NUM_CONSOLES];
    logic [IDX_W-1:0]     active_reg;
    logic [ATTR_W-1:0]    attr_reg;

    // result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    // update path
    logic                 advance;
    logic                 in_range;
    logic [IDX_W-1:0]     sel;
    logic [CELL_W-1:0]    origin;
    logic [OFF_W-1:0]     cur_off;
    logic [ROW_W-1:0]     cur_row;
    logic [COL_W-1:0]     cur_col;
    logic [OFF_W-1:0]     win_off;
    logic [ROW_W-1:0]     win_row;
    logic [OFF_W-1:0]     cur_off_next;
    logic [ROW_W-1:0]     cur_row_next;
    logic [COL_W-1:0]     cur_col_next;
    logic [OFF_W-1:0]     win_off_next;
    logic [ROW_W-1:0]     win_row_next;
    logic [IDX_W-1:0]     active_next;
    logic [SUM_W-1:0]     target_row;
    logic                 wr;
    logic [OFF_W-1:0]     wr_off;
    logic [CHAR_W-1:0]    wr_char;
    logic                 fl;
    logic [OFF_W-1:0]     fl_cur;
    logic [OFF_W-1:0]     fl_win;
    logic [M_TDATA_W-1:0] m_data_next;
    logic [M_TUSER_W-1:0] m_user_next;

    // handshake
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // console lookup
    assign in_range = {1'b0, idx_reg} < (CIDX_W + 1)'(NUM_CONSOLES);
    assign sel      = IDX_W'(idx_reg);
    assign origin   = CELL_W'(idx_reg * CELL_W'(CONSOLE_CELLS));
    assign cur_off  = cur_off_reg[sel];
    assign cur_row  = cur_row_reg[sel];
    assign cur_col  = cur_col_reg[sel];
    assign win_off  = win_off_reg[sel];
    assign win_row  = win_row_reg[sel];

    // command decode and cursor/view update
    always_comb begin
        cur_off_next = cur_off;
        cur_row_next = cur_row;
        cur_col_next = cur_col;
        win_off_next = win_off;
        win_row_next = win_row;
        active_next  = active_reg;
        target_row   = '0;
        wr           = 1'b0;
        wr_off       = '0;
        wr_char      = '0;
        fl           = 1'b0;
        fl_cur       = '0;
        fl_win       = '0;
        if (in_range) begin
            case (cmd_reg)
                CMD_PUT: begin
                    if (char_reg == CHR_NEWLINE) begin
                        if (SUM_W'(cur_off) + COLS_S < CELLS_S) begin
                            cur_off_next = OFF_W'(SUM_W'(cur_off) - SUM_W'(cur_col) + COLS_S);
                            cur_row_next = cur_row + ROW_W'(1);
                            cur_col_next = '0;
                        end
                    end else if (char_reg == CHR_BACKSPACE) begin
                        if (cur_off != '0) begin
                            cur_off_next = cur_off - OFF_W'(1);
                            wr           = 1'b1;
                            wr_off       = cur_off - OFF_W'(1);
                            wr_char      = CHR_BLANK;
                            if (cur_col == '0) begin
                                cur_col_next = LAST_COL;
                                cur_row_next = cur_row - ROW_W'(1);
                            end else begin
                                cur_col_next = cur_col - COL_W'(1);
                            end
                        end
                    end else begin
                        if (SUM_W'(cur_off) + SUM_W'(1) < CELLS_S) begin
                            cur_off_next = cur_off + OFF_W'(1);
                            wr           = 1'b1;
                            wr_off       = cur_off;
                            wr_char      = char_reg;
                            if (cur_col == LAST_COL) begin
                                cur_col_next = '0;
                                cur_row_next = cur_row + ROW_W'(1);
                            end else begin
                                cur_col_next = cur_col + COL_W'(1);
                            end
                        end
                    end
                    // follow the cursor down, as far as the slice allows
                    if (SUM_W'(cur_row_next) >= SUM_W'(win_row) + ROWS_S) begin
                        target_row = SUM_W'(cur_row_next) - ROWS_S + SUM_W'(1);
                        if (target_row <= MAXROW_S) begin
                            win_row_next = ROW_W'(target_row);
                            win_off_next = OFF_W'(SUM_W'(cur_off_next) - SUM_W'(cur_col_next)
                                                  + COLS_S - VIEW_S);
                        end else begin
                            win_row_next = ROW_W'(MAX_ROW);
                            win_off_next = OFF_W'(MAX_WO);
                        end
                    end
                    if (sel == active_reg) begin
                        fl     = 1'b1;
                        fl_cur = cur_off_next;
                        fl_win = win_off_next;
                    end
                end
                CMD_UP: begin
                    if (win_off != '0) begin
                        win_off_next = win_off - OFF_W'(SCREEN_COLS);
                        win_row_next = win_row - ROW_W'(1);
                    end
                end
                CMD_DOWN: begin
                    if (SUM_W'(win_off) + VIEW_S < CELLS_S) begin
                        win_off_next = win_off + OFF_W'(SCREEN_COLS);
                        win_row_next = win_row + ROW_W'(1);
                    end
                end
                CMD_SELECT: begin
                    active_next = sel;
                    fl          = 1'b1;
                    fl_cur      = cur_off;
                    fl_win      = win_off;
                end
                default: begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    // result packing, unused fields zero
    always_comb begin
        m_data_next = '0;
        m_user_next = {fl, wr};
        if (wr) begin
            m_data_next[13:0]  = origin + CELL_W'(wr_off);
            m_data_next[21:14] = wr_char;
            m_data_next[29:22] = attr_reg;
        end
        if (fl) begin
            m_data_next[43:30] = origin + CELL_W'(fl_cur);
            m_data_next[57:44] = origin + CELL_W'(fl_win);
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            cmd_reg  <= cmd_t'(s_tuser);
            idx_reg  <= s_tdata[2:0];
            char_reg <= s_tdata[10:3];
        end
    end

    // console state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CONSOLES; i++) begin
                cur_off_reg[i] <= '0;
                cur_row_reg[i] <= '0;
                cur_col_reg[i] <= '0;
                win_off_reg[i] <= '0;
                win_row_reg[i] <= '0;
            end
            active_reg <= '0;
        end else if (advance && in_range) begin
            cur_off_reg[sel] <= cur_off_next;
            cur_row_reg[sel] <= cur_row_next;
            cur_col_reg[sel] <= cur_col_next;
            win_off_reg[sel] <= win_off_next;
            win_row_reg[sel] <= win_row_next;
            active_reg       <= active_next;
        end
    end

    // attribute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_we) begin
            attr_reg <= cfg_wdata;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

`ifndef SYNTHESIS
    // the input side only stalls behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
    else $error("input stalled without a held result");

    // the cursor never leaves its slice
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> (SUM_W'(cur_off_next) < CELLS_S))
    else $error("cursor offset beyond slice");

    // the cursor column stays within the screen width
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> (SUM_W'(cur_col_next) < COLS_S))
    else $error("cursor column out of range");

    // a command that advances out of the input register shows its result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
    else $error("result missing after update");
`endif

endmodule

// File: tb/tb_text_console_cursor_engine_unit.sv
// self-checking testbench for the text console cursor engine
module tb_text_console_cursor_engine_unit;
    import tcce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // block configuration under test
    localparam int NCON      = 4;
    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int SLICE     = 4096;
    localparam int VIEW      = COLS * ROWS;
    localparam int STALL_MAX = 2000;
    localparam int LONG_HOLD = 120;
    localparam int PHASES    = 6;
    localparam int PHASE_QUOTA = 150;
    localparam int MAX_PRINT = 25;

    // one result transaction, field by field
    typedef struct packed {
        logic              wr;
        logic [CELL_W-1:0] wcell;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic              fl;
        logic [CELL_W-1:0] cpos;
        logic [CELL_W-1:0] vstart;
    } cell_result_t;

    // one row of the directed table
    typedef struct {
        cmd_t              cmd;
        logic [CIDX_W-1:0] con;
        logic [CHAR_W-1:0] ch;
        bit                given;
        cell_result_t      res;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = CMD_PUT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we = 1'b0;
    logic [ATTR_W-1:0]    cfg_wdata = '0;

    // predictor state
    int              cursor_at [NCON];
    int              window_at [NCON];
    int              active_con;
    logic [ATTR_W-1:0] attr_now;

    cell_result_t pending_results [$];
    stim_row_t    dir_rows [$];

    int mismatch_count = 0;
    int n_commands = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_flushes = 0;
    int n_slice_full = 0;
    int n_auto_scroll = 0;
    int burst_left = 0;
    bit hold_done = 1'b0;

    text_console_cursor_engine_unit #(
        .NUM_CONSOLES (NCON),
        .SCREEN_COLS  (COLS),
        .SCREEN_ROWS  (ROWS),
        .CONSOLE_CELLS(SLICE)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // cursor and view predictor: one command in, one result out
    function automatic cell_result_t predict_console(input cmd_t cmd,
                                                     input logic [CIDX_W-1:0] con,
                                                     input logic [CHAR_W-1:0] ch);
        cell_result_t r;
        int c;
        int org;
        int lim;
        int pos;
        int first_view;
        r = '0;
        c = con;
        if (c < NCON) begin
            org = c * SLICE;
            lim = org + SLICE;
            case (cmd)
                CMD_PUT: begin
                    pos = cursor_at[c];
                    if (ch == CHR_NEWLINE) begin
                        if (pos + COLS < lim)
                            pos = org + COLS * ((pos - org) / COLS + 1);
                    end else if (ch == CHR_BACKSPACE) begin
                        if (pos > org) begin
                            pos = pos - 1;
                            r.wr = 1'b1;
                            r.wcell = CELL_W'(pos);
                            r.ch = CHR_BLANK;
                            r.attr = attr_now;
                        end
                    end else if (pos + 1 < lim) begin
                        r.wr = 1'b1;
                        r.wcell = CELL_W'(pos);
                        r.ch = ch;
                        r.attr = attr_now;
                        pos = pos + 1;
                    end else begin
                        n_slice_full++;
                    end
                    cursor_at[c] = pos;
                    // follow the cursor down while the slice allows
                    first_view = window_at[c];
                    while (pos >= window_at[c] + VIEW && window_at[c] + VIEW < lim)
                        window_at[c] = window_at[c] + COLS;
                    if (window_at[c] != first_view)
                        n_auto_scroll++;
                    if (c == active_con) begin
                        r.fl = 1'b1;
                        r.cpos = CELL_W'(pos);
                        r.vstart = CELL_W'(window_at[c]);
                    end
                end
                CMD_UP: begin
                    if (window_at[c] > org)
                        window_at[c] = window_at[c] - COLS;
                end
                CMD_DOWN: begin
                    if (window_at[c] + VIEW < lim)
                        window_at[c] = window_at[c] + COLS;
                end
                default: begin
                    active_con = c;
                    r.fl = 1'b1;
                    r.cpos = CELL_W'(cursor_at[c]);
                    r.vstart = CELL_W'(window_at[c]);
                end
            endcase
        end
        return r;
    endfunction

    function automatic cell_result_t mk_res(input int wr, input int wcell,
                                            input int ch, input int attr,
                                            input int fl, input int cpos,
                                            input int vstart);
        cell_result_t r;
        r.wr = 1'(wr);
        r.wcell = CELL_W'(wcell);
        r.ch = CHAR_W'(ch);
        r.attr = ATTR_W'(attr);
        r.fl = 1'(fl);
        r.cpos = CELL_W'(cpos);
        r.vstart = CELL_W'(vstart);
        return r;
    endfunction

    function automatic stim_row_t mk_row(input cmd_t cmd, input int con, input int ch,
                                         input bit given, input cell_result_t res);
        stim_row_t row;
        row.cmd = cmd;
        row.con = CIDX_W'(con);
        row.ch = CHAR_W'(ch);
        row.given = given;
        row.res = res;
        return row;
    endfunction

    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // mostly valid consoles, now and then one that is ignored
    function automatic logic [CIDX_W-1:0] pick_console();
        if ($urandom_range(0, 9) == 0)
            return CIDX_W'($urandom_range(NCON, 7));
        return CIDX_W'($urandom_range(0, NCON - 1));
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (mismatch_count < MAX_PRINT)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        mismatch_count++;
    endtask

    // offer one command, predict it on acceptance, then maybe pause the source
    task automatic push_command(input cmd_t cmd, input logic [CIDX_W-1:0] con,
                                input logic [CHAR_W-1:0] ch, input bit given,
                                input cell_result_t given_res);
        cell_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_W - CHAR_W - CIDX_W){1'b0}}, ch, con};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_console(cmd, con, ch);
        pending_results.push_back(given ? given_res : predicted);
        n_commands++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 16);
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // stop offering, let every result drain and the pipeline settle
    task automatic drain_results();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        attr_now = value;
    endtask

    // random episodes: line runs, text runs, erasing, scrolling, selects, noise
    task automatic run_random_phase(input int quota, input bit with_fill);
        int sent;
        int len;
        int sel;
        int i;
        logic [CIDX_W-1:0] con;
        logic [CHAR_W-1:0] ch;
        cmd_t cmd;
        sent = 0;
        // drive one console to the end of its slice
        if (with_fill) begin
            con = CIDX_W'($urandom_range(0, NCON - 1));
            for (i = 0; i < 55; i++)
                push_command(CMD_PUT, con, CHR_NEWLINE, 1'b0, '0);
            for (i = 0; i < 18; i++)
                push_command(CMD_PUT, con, any_char(), 1'b0, '0);
            sent = 73;
        end
        while (sent < quota) begin
            con = pick_console();
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                // line run, mostly newlines
                len = $urandom_range(20, 70);
                for (i = 0; i < len; i++) begin
                    ch = ($urandom_range(0, 4) != 0) ? CHR_NEWLINE : any_char();
                    push_command(CMD_PUT, con, ch, 1'b0, '0);
                end
            end else if (sel < 60) begin
                // text run with the odd erase and newline
                len = $urandom_range(5, 40);
                for (i = 0; i < len; i++) begin
                    sel = $urandom_range(0, 19);
                    ch = (sel < 2) ? CHR_BACKSPACE : (sel == 2) ? CHR_NEWLINE : any_char();
                    push_command(CMD_PUT, con, ch, 1'b0, '0);
                end
            end else if (sel < 72) begin
                // erase run
                len = $urandom_range(5, 30);
                for (i = 0; i < len; i++)
                    push_command(CMD_PUT, con, CHR_BACKSPACE, 1'b0, '0);
            end else if (sel < 84) begin
                // view scrolling
                len = $urandom_range(3, 30);
                for (i = 0; i < len; i++) begin
                    cmd = ($urandom_range(0, 1) == 0) ? CMD_UP : CMD_DOWN;
                    push_command(cmd, con, any_char(), 1'b0, '0);
                end
            end else if (sel < 94) begin
                len = 1;
                con = CIDX_W'($urandom_range(0, 7));
                push_command(CMD_SELECT, con, any_char(), 1'b0, '0);
            end else begin
                // noise over every field
                len = 0;
                for (i = $urandom_range(1, 8); i > 0; i--) begin
                    cmd = cmd_t'($urandom_range(0, 3));
                    con = CIDX_W'($urandom_range(0, 7));
                    push_command(cmd, con, any_char(), 1'b0, '0);
                    sent++;
                end
            end
            sent += len;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        cell_result_t got;
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.wr = m_tuser[0];
            got.fl = m_tuser[1];
            got.wcell = m_tdata[13:0];
            got.ch = m_tdata[21:14];
            got.attr = m_tdata[29:22];
            got.cpos = m_tdata[43:30];
            got.vstart = m_tdata[57:44];
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (want.wr)
                    n_writes++;
                if (want.fl)
                    n_flushes++;
                if (got.wr !== want.wr)
                    report_mismatch("mem_write", got.wr, want.wr);
                if (got.wcell !== want.wcell)
                    report_mismatch("mem_cell", got.wcell, want.wcell);
                if (got.ch !== want.ch)
                    report_mismatch("mem_char", got.ch, want.ch);
                if (got.attr !== want.attr)
                    report_mismatch("mem_attr", got.attr, want.attr);
                if (got.fl !== want.fl)
                    report_mismatch("flush", got.fl, want.fl);
                if (got.cpos !== want.cpos)
                    report_mismatch("cursor_pos", got.cpos, want.cpos);
                if (got.vstart !== want.vstart)
                    report_mismatch("view_start", got.vstart, want.vstart);
            end
        end
    end

    // result sink: rotating stall patterns plus one long hold-off
    initial begin : sink_proc
        int cyc;
        int mode;
        logic [6:0] pattern;
        cyc = 0;
        pattern = 7'b1011001;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            cyc++;
            if (!hold_done && n_results >= 270) begin
                // hold off long enough for the block to back up
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                mode = (cyc / 256) % 4;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= pattern[cyc % 7];
                    default: m_tready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin : watchdog_proc
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_MAX);
        $display("FAIL text_console_cursor_engine_unit");
        $finish;
    end

    // main sequence
    initial begin : main_seq
        logic [ATTR_W-1:0] attr_plan [PHASES];
        int p;
        int c;
        for (c = 0; c < NCON; c++) begin
            cursor_at[c] = c * SLICE;
            window_at[c] = c * SLICE;
        end
        active_con = 0;
        attr_now = ATTR_RESET;

        // directed table: reset state, ignored consoles, slice edges, each command
        dir_rows.push_back(mk_row(CMD_PUT, 0, 65, 1'b1, mk_res(1, 0, 65, 7, 1, 1, 0)));
        dir_rows.push_back(mk_row(CMD_PUT, 5, 66, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_SELECT, 7, 0, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_UP, 6, 255, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 1, CHR_BACKSPACE, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 0, CHR_BACKSPACE, 1'b1,
                                  mk_res(1, 0, CHR_BLANK, 7, 1, 0, 0)));
        dir_rows.push_back(mk_row(CMD_PUT, 0, CHR_BACKSPACE, 1'b1,
                                  mk_res(0, 0, 0, 0, 1, 0, 0)));
        dir_rows.push_back(mk_row(CMD_UP, 0, 0, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_DOWN, 2, 0, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_SELECT, 2, 0, 1'b1,
                                  mk_res(0, 0, 0, 0, 1, 8192, 8272)));
        dir_rows.push_back(mk_row(CMD_PUT, 2, CHR_NEWLINE, 1'b1,
                                  mk_res(0, 0, 0, 0, 1, 8272, 8272)));
        dir_rows.push_back(mk_row(CMD_PUT, 2, 255, 1'b1,
                                  mk_res(1, 8272, 255, 7, 1, 8273, 8272)));
        dir_rows.push_back(mk_row(CMD_PUT, 2, 0, 1'b1,
                                  mk_res(1, 8273, 0, 7, 1, 8274, 8272)));
        dir_rows.push_back(mk_row(CMD_UP, 2, 0, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 2, CHR_NEWLINE, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 1, 122, 1'b1,
                                  mk_res(1, 4096, 122, 7, 0, 0, 0)));
        dir_rows.push_back(mk_row(CMD_SELECT, 3, 0, 1'b1,
                                  mk_res(0, 0, 0, 0, 1, 12288, 12288)));
        dir_rows.push_back(mk_row(CMD_PUT, 3, 9, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 3, 11, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 3, 7, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_DOWN, 3, 0, 1'b0, '0));
        dir_rows.push_back(mk_row(CMD_SELECT, 0, 0, 1'b1, mk_res(0, 0, 0, 0, 1, 0, 0)));
        dir_rows.push_back(mk_row(CMD_SELECT, 4, 0, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 7, 255, 1'b1, '0));
        dir_rows.push_back(mk_row(CMD_PUT, 3, 81, 1'b0, '0));

        // attribute per random phase, extremes first
        attr_plan[0] = 8'h00;
        attr_plan[1] = 8'hFF;
        attr_plan[2] = any_char();
        attr_plan[3] = 8'h5A;
        attr_plan[4] = 8'hA5;
        attr_plan[5] = any_char();

        // synchronous reset
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = $urandom_range(1, 16);
        foreach (dir_rows[i])
            push_command(dir_rows[i].cmd, dir_rows[i].con, dir_rows[i].ch,
                         dir_rows[i].given, dir_rows[i].res);
        drain_results();

        for (p = 0; p < PHASES; p++) begin
            write_attr(attr_plan[p]);
            run_random_phase(PHASE_QUOTA, p % 2 == 1);
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results still outstanding", pending_results.size(), 0);

        $display("covered %0d commands, %0d results over %0d attribute settings",
                 n_commands, n_results, PHASES + 1);
        $display("%0d cell writes, %0d flushes, %0d puts at a full slice, %0d view follows",
                 n_writes, n_flushes, n_slice_full, n_auto_scroll);
        if (mismatch_count == 0) begin
            $display("PASS text_console_cursor_engine_unit");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL text_console_cursor_engine_unit");
        end
        $finish;
    end

endmodule
